>>> src/ppmf_pkg.sv
// Shared types and constants of the projected point mask filter.
`default_nettype none
package ppmf_pkg;

  // Width of the projection numerator handed to the divider.
  localparam int unsigned RW = 55;
  // Width of the doubled denominator 2*z*256.
  localparam int unsigned DW = 40;

  // Register map, one word per register.
  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_MASK_COLS = 3'd4,
    REG_MASK_ROWS = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERDICT_KEPT    = 2'd0,
    VERDICT_INVALID = 2'd1,
    VERDICT_OUTSIDE = 2'd2,
    VERDICT_MASKED  = 2'd3
  } verdict_e;

  // Sideband of one request as it travels down the pipeline.
  typedef struct packed {
    logic        is_pt;
    logic        wbit;
    logic [19:0] idx;
    logic        fin;
    logic        inv;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } item_t;

endpackage
`default_nettype wire

>>> src/ppmf_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module ppmf_ram #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] addr_i,
  input  wire  [W-1:0]             wdata_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  // Write and registered read share the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

>>> src/ppmf_div.sv
// Pipelined restoring divider for both projection axes, one quotient bit per stage.
`default_nettype none
module ppmf_div #(
  parameter int unsigned QW = 13,
  parameter int unsigned TW = 1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  wire                   valid_i,
  input  wire  [TW-1:0]         tag_i,
  input  wire  [ppmf_pkg::RW-1:0] nx_i,
  input  wire  [ppmf_pkg::RW-1:0] ny_i,
  input  wire  [ppmf_pkg::DW-1:0] d_i,
  output logic                  valid_o,
  output logic [TW-1:0]         tag_o,
  output logic [QW-1:0]         qx_o,
  output logic [QW-1:0]         qy_o,
  output logic                  ovfx_o,
  output logic                  ovfy_o
);
  import ppmf_pkg::*;

  logic          v_q    [QW+1];
  logic [TW-1:0] tag_q  [QW+1];
  logic [RW-1:0] rx_q   [QW+1];
  logic [RW-1:0] ry_q   [QW+1];
  logic [QW-1:0] qx_q   [QW+1];
  logic [QW-1:0] qy_q   [QW+1];
  logic [DW-1:0] d_q    [QW+1];
  logic          ovfx_q [QW+1];
  logic          ovfy_q [QW+1];

  // Entry stage: a quotient that needs more than QW bits is flagged as overflow.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0]  <= tag_i;
      rx_q[0]   <= nx_i;
      ry_q[0]   <= ny_i;
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      d_q[0]    <= d_i;
      ovfx_q[0] <= nx_i >= (RW'(d_i) << QW);
      ovfy_q[0] <= ny_i >= (RW'(d_i) << QW);
    end
  end

  // One compare and subtract per stage, most significant quotient bit first.
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int unsigned SH = QW - 1 - k;
    logic [RW-1:0] trial;
    logic          hitx;
    logic          hity;

    assign trial = RW'(d_q[k]) << SH;
    assign hitx  = rx_q[k] >= trial;
    assign hity  = ry_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k+1]  <= tag_q[k];
        d_q[k+1]    <= d_q[k];
        ovfx_q[k+1] <= ovfx_q[k];
        ovfy_q[k+1] <= ovfy_q[k];
        rx_q[k+1]   <= hitx ? rx_q[k] - trial : rx_q[k];
        ry_q[k+1]   <= hity ? ry_q[k] - trial : ry_q[k];
        qx_q[k+1]   <= qx_q[k] | (QW'(hitx) << SH);
        qy_q[k+1]   <= qy_q[k] | (QW'(hity) << SH);
      end
    end
  end

  assign valid_o = v_q[QW];
  assign tag_o   = tag_q[QW];
  assign qx_o    = qx_q[QW];
  assign qy_o    = qy_q[QW];
  assign ovfx_o  = ovfx_q[QW];
  assign ovfy_o  = ovfy_q[QW];

endmodule
`default_nettype wire

>>> src/projected_point_mask_filter.sv
// Top level: projects points onto a bit mask held in RAM and filters them.
// A point request passes stages 1 to 3, the divider, stage 6, the mask RAM read and
// stage 7, then the output register. Throughput: one request per cycle while the skid
// register is empty; mask writes and points share the single RAM port.
// Reset clears all valid flags and loads the register defaults; mask RAM
// contents are undefined until written and are not cleared.
`default_nettype none
module projected_point_mask_filter #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  // Input stream.
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: mask_index[19:0], mask_byte[27:20], point_finite[28], x_in[60:29],
  //        y_in[92:61], z_in[124:93], zero[127:125]
  input  wire  [127:0] s_axis_tdata,
  // tuser: req_type[0]
  input  wire          s_axis_tuser,
  // Output stream.
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // tdata: x_out[31:0], y_out[63:32], z_out[95:64], finite_out[96], zero[103:97]
  output logic [103:0] m_axis_tdata,
  // tuser: verdict[1:0]
  output logic [1:0]   m_axis_tuser,
  // Configuration port.
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [4:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ppmf_pkg::*;

  localparam int unsigned MAXD  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int unsigned QW    = $clog2(MAXD) + 1;
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned RWID  = $clog2(MAX_ROWS + 1);
  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = QW + CW;
  localparam int unsigned TW    = $bits(item_t) + 2;

  // Configuration registers.
  logic [19:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [10:0] mask_cols_q, mask_rows_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q   <= 20'd153600;
      focal_y_q   <= 20'd153600;
      center_x_q  <= 20'd81920;
      center_y_q  <= 20'd61440;
      mask_cols_q <= 11'd640;
      mask_rows_q <= 11'd480;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[4:2]))
        REG_FOCAL_X:   focal_x_q   <= pwdata[19:0];
        REG_FOCAL_Y:   focal_y_q   <= pwdata[19:0];
        REG_CENTER_X:  center_x_q  <= pwdata[19:0];
        REG_CENTER_Y:  center_y_q  <= pwdata[19:0];
        REG_MASK_COLS: mask_cols_q <= pwdata[10:0];
        REG_MASK_ROWS: mask_rows_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_reg_e'(paddr[4:2]))
      REG_FOCAL_X:   prdata = 32'(focal_x_q);
      REG_FOCAL_Y:   prdata = 32'(focal_y_q);
      REG_CENTER_X:  prdata = 32'(center_x_q);
      REG_CENTER_Y:  prdata = 32'(center_y_q);
      REG_MASK_COLS: prdata = 32'(mask_cols_q);
      REG_MASK_ROWS: prdata = 32'(mask_rows_q);
      default:       prdata = '0;
    endcase
  end

  // Frame size saturated to the store dimensions.
  logic [CW-1:0]   cols;
  logic [RWID-1:0] rows;
  assign cols = (32'(mask_cols_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(mask_cols_q);
  assign rows = (32'(mask_rows_q) > MAX_ROWS) ? RWID'(MAX_ROWS) : RWID'(mask_rows_q);

  // Pipeline advances unless the skid register is occupied.
  logic en;
  logic skid_v_q;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // Stage 1: capture request and form the four products.
  item_t              it_in;
  logic               acc;
  logic signed [31:0] x_s, y_s, z_s;

  assign acc          = s_axis_tvalid && s_axis_tready;
  assign x_s          = s_axis_tdata[60:29];
  assign y_s          = s_axis_tdata[92:61];
  assign z_s          = s_axis_tdata[124:93];
  assign it_in.is_pt  = s_axis_tuser;
  assign it_in.wbit   = |s_axis_tdata[27:20];
  assign it_in.idx    = s_axis_tdata[19:0];
  assign it_in.fin    = s_axis_tdata[28];
  assign it_in.inv    = !s_axis_tdata[28] || (z_s <= 32'sd0);
  assign it_in.x      = x_s;
  assign it_in.y      = y_s;
  assign it_in.z      = z_s;

  logic               v1_q;
  item_t              it1_q;
  logic signed [52:0] px1_q, py1_q, cxz1_q, cyz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q  <= it_in;
      px1_q  <= x_s * $signed({1'b0, focal_x_q});
      py1_q  <= y_s * $signed({1'b0, focal_y_q});
      cxz1_q <= z_s * $signed({1'b0, center_x_q});
      cyz1_q <= z_s * $signed({1'b0, center_y_q});
    end
  end

  // Stage 2: numerators x*f + c*z and the doubled denominator.
  logic               v2_q;
  item_t              it2_q;
  logic signed [53:0] numx2_q, numy2_q;
  logic [DW-1:0]      d2_q;
  logic signed [53:0] numx_d, numy_d;

  assign numx_d = px1_q + cxz1_q;
  assign numy_d = py1_q + cyz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it2_q   <= it1_q;
      numx2_q <= numx_d;
      numy2_q <= numy_d;
      d2_q    <= {it1_q.z[30:0], 9'b0};
    end
  end

  // Stage 3: rounded dividend 2*|num| + den, sign kept aside.
  logic               v3_q;
  item_t              it3_q;
  logic [RW-1:0]      nx3_q, ny3_q;
  logic [DW-1:0]      d3_q;
  logic               negx3_q, negy3_q;
  logic signed [53:0] magx, magy;

  assign magx = numx2_q[53] ? -numx2_q : numx2_q;
  assign magy = numy2_q[53] ? -numy2_q : numy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it3_q   <= it2_q;
      nx3_q   <= RW'({magx[52:0], 1'b0}) + RW'(d2_q[DW-1:1]);
      ny3_q   <= RW'({magy[52:0], 1'b0}) + RW'(d2_q[DW-1:1]);
      d3_q    <= d2_q;
      negx3_q <= numx2_q[53];
      negy3_q <= numy2_q[53];
    end
  end

  // Divider stages.
  logic          vdv;
  logic [TW-1:0] tagdv;
  logic [QW-1:0] qx, qy;
  logic          ovfx, ovfy;

  ppmf_div #(
    .QW(QW),
    .TW(TW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .tag_i   ({it3_q, negx3_q, negy3_q}),
    .nx_i    (nx3_q),
    .ny_i    (ny3_q),
    .d_i     (d3_q),
    .valid_o (vdv),
    .tag_o   (tagdv),
    .qx_o    (qx),
    .qy_o    (qy),
    .ovfx_o  (ovfx),
    .ovfy_o  (ovfy)
  );

  // Stage 6: frame test and pixel address.
  item_t   itdv;
  logic    negx, negy, oob;
  logic [PW-1:0] pix;

  assign itdv = tagdv[TW-1:2];
  assign negx = tagdv[1];
  assign negy = tagdv[0];
  assign oob  = ovfx || (negx && (|qx)) || (32'(qx) >= 32'(cols)) ||
                ovfy || (negy && (|qy)) || (32'(qy) >= 32'(rows));
  assign pix  = PW'(qy) * PW'(cols) + PW'(qx);

  logic          v6_q;
  item_t         it6_q;
  logic          oob6_q;
  logic [AW-1:0] pix6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= vdv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it6_q  <= itdv;
      oob6_q <= oob;
      pix6_q <= AW'(pix);
    end
  end

  // Mask RAM: writes and point look-ups take the port in request order.
  logic          ram_we, ram_re, ram_rd;
  logic [AW-1:0] ram_addr;

  assign ram_we   = en && v6_q && !it6_q.is_pt && (32'(it6_q.idx) < DEPTH);
  assign ram_re   = en && v6_q && it6_q.is_pt && !it6_q.inv && !oob6_q;
  assign ram_addr = it6_q.is_pt ? pix6_q : AW'(it6_q.idx);

  ppmf_ram #(
    .W    (1),
    .DEPTH(DEPTH)
  ) u_mask (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (it6_q.wbit),
    .rdata_o (ram_rd)
  );

  // Stage 7: wait for the mask bit.
  logic  v7_q;
  item_t it7_q;
  logic  oob7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it7_q  <= it6_q;
      oob7_q <= oob6_q;
    end
  end

  // Verdict and result payload.
  logic       fin_v;
  logic [103:0] res_data;
  verdict_e   res_verdict;

  assign fin_v = v7_q && it7_q.is_pt;

  always_comb begin
    res_data = '0;
    if (it7_q.inv) begin
      res_verdict = VERDICT_INVALID;
      res_data    = {7'b0, it7_q.fin, it7_q.z, it7_q.y, it7_q.x};
    end else if (oob7_q) begin
      res_verdict = VERDICT_OUTSIDE;
    end else if (ram_rd) begin
      res_verdict = VERDICT_KEPT;
      res_data    = {7'b0, 1'b1, it7_q.z, it7_q.y, it7_q.x};
    end else begin
      res_verdict = VERDICT_MASKED;
    end
  end

  // Output register with skid stage.
  logic [103:0] skid_data_q;
  logic [1:0]   skid_user_q;
  logic         out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
      skid_v_q      <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= skid_v_q || (en && fin_v);
      skid_v_q      <= 1'b0;
    end else if (en && fin_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        m_axis_tdata <= skid_data_q;
        m_axis_tuser <= skid_user_q;
      end else begin
        m_axis_tdata <= res_data;
        m_axis_tuser <= res_verdict;
      end
    end else if (en && fin_v) begin
      skid_data_q <= res_data;
      skid_user_q <= res_verdict;
    end
  end

endmodule
`default_nettype wire
